// ===== hw/rtl/ordered_value_list_macros.svh =====
// Assertion macros for the ordered value list checker.
// Each macro expects a clock named i_clk in scope; OVL_ASSERT also expects an active-low reset i_rst_n.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is held.
`define OVL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define OVL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ovl_pkg.sv =====
// Shared types and constants for the ordered value list.
// No dependencies; used by the top level and the checker.
package ovl_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths of the stream beats.
    localparam int ACTION_W     = 2;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_REMOVE = 2'd2
    } t_action;

endpackage

// ===== hw/rtl/ovl_ram.sv =====
// Entry storage of the ordered value list: one write port, one read port.
// Read data is registered, so it appears in the cycle after the read enable.
module ovl_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/ordered_value_list.sv =====
// Ordered value list: top level with the operation sequencer and the result register.
// Depends on ovl_pkg and on ovl_ram, which holds the entries.
//
// The block keeps up to CAPACITY signed values in the order they were appended,
// packed from the head at slot 0 to the tail at slot count-1 in a single-port-read
// RAM. Each input beat carries an action in tuser (append, membership query, or
// remove of the first match from the head) and a value in tdata; each beat yields
// exactly one result beat with a success flag, the entry count after the operation,
// and a full flag. Values are compared over their low VALUE_WIDTH bits. One item is
// worked on at a time. An append goes straight to the finish state, where its result
// is loaded once the output register is free. A query or remove walks the list
// through the RAM read port, one entry per cycle, and a remove writes each later
// entry one slot toward the head as it passes; a query stops reading once it has
// found a match. The next input beat is accepted in the cycle after the result is
// loaded. The result waits in an output register, and the next input beat is
// accepted while it waits; an item that finishes while that register still holds
// an untaken beat stalls until the beat is taken. Entries need no clearing after
// reset: only slots below the count are ever read, and each of those has been
// written.
module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input beats.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic [ACTION_W-1:0]    i_s_tuser,   // [1:0] action
    // Result beats.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [0] success, [5:1] count, [6] full_res, [7] zero
);

    // Stored width: values arrive as 32 bits, so nothing above that can differ.
    localparam int SW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    // Address width for the slots, and counter width that can hold CAPACITY itself.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state          r_state;
    t_action         r_act;
    logic [SW-1:0]   r_val;
    logic [CW-1:0]   r_occ;
    logic [CW-1:0]   r_rd_addr;
    logic            r_pend;
    logic [AW-1:0]   r_pend_addr;
    logic            r_found;
    logic            r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [SW-1:0]   rd_data;
    logic            rd_issue;
    logic            match;
    logic            out_free;
    logic            out_load;
    logic            accept;
    logic            room;
    logic            ok;
    logic [CW-1:0]   n_occ;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [SW-1:0]   wr_data;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign out_load = (r_state == ST_FINISH) && out_free;
    assign room     = r_occ < CW'(CAPACITY);

    // The scan reads one slot per cycle; a query stops once a match is known.
    assign rd_issue = (r_state == ST_SCAN) && (r_rd_addr < r_occ)
                      && !(r_found && (r_act == ACT_QUERY));
    // Only the first match nearest the head counts.
    assign match    = r_pend && !r_found && (rd_data == r_val);

    // Outcome of the item and the count after it, applied in the finish state.
    always_comb begin
        ok    = 1'b0;
        n_occ = r_occ;
        unique case (r_act)
            ACT_APPEND: begin
                ok = room;
                if (room) begin
                    n_occ = r_occ + CW'(1);
                end
            end
            ACT_QUERY: begin
                ok = r_found;
            end
            ACT_REMOVE: begin
                ok = r_found;
                if (r_found) begin
                    n_occ = r_occ - CW'(1);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // At most one RAM write per cycle: either a shifted entry during a remove, moved from the
    // slot just read into the slot before it, or the new tail on an append. Reads run
    // ahead of these writes, so a slot is never read after it was rewritten.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr - AW'(1);
        wr_data = rd_data;
        if ((r_state == ST_SCAN) && r_pend && r_found && (r_act == ACT_REMOVE)) begin
            wr_en = 1'b1;
        end else if ((r_state == ST_FINISH) && out_free && (r_act == ACT_APPEND) && room) begin
            wr_en   = 1'b1;
            wr_addr = r_occ[AW-1:0];
            wr_data = r_val;
        end
    end

    ovl_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (SW),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_addr   <= '0;
        end else begin
            // A new result may be loaded in the same cycle the waiting one is taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_act     <= t_action'(i_s_tuser);
                        r_val     <= i_s_tdata[SW-1:0];
                        r_rd_addr <= '0;
                        r_pend    <= 1'b0;
                        r_found   <= 1'b0;
                        if ((t_action'(i_s_tuser) == ACT_QUERY)
                            || (t_action'(i_s_tuser) == ACT_REMOVE)) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend <= rd_issue;
                    if (rd_issue) begin
                        r_pend_addr <= r_rd_addr[AW-1:0];
                        r_rd_addr   <= r_rd_addr + CW'(1);
                    end
                    if (match) begin
                        r_found <= 1'b1;
                    end
                    if (!rd_issue && !r_pend) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_occ       <= n_occ;
                        r_out_data  <= {1'b0, (n_occ == CW'(CAPACITY)),
                                        COUNT_W'(n_occ), ok};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hw/rtl/ovl_checker.sv =====
// Port-level checker for the ordered value list, bound to the top level.
// Depends on ovl_pkg and on the macros in ordered_value_list_macros.svh.
`include "ordered_value_list_macros.svh"

module ovl_checker
    import ovl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [COUNT_W-1:0] count;
    logic               full_res;
    logic               cap_narrow;

    assign count      = o_m_tdata[COUNT_W:1];
    assign full_res   = o_m_tdata[COUNT_W+1];
    assign cap_narrow = (CAPACITY < (1 << COUNT_W));

    // A result beat that is not taken stays offered.
    `OVL_ASSERT(a_out_hold, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "result beat dropped")

    // Only one item is in work: after an input beat the block takes no other at once.
    `OVL_ASSERT(a_one_item, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "second item taken")

    // The count never goes past the capacity.
    `OVL_ASSERT(a_count_max, (o_m_tvalid && cap_narrow) |-> (count <= COUNT_W'(CAPACITY)), "count above capacity")

    // The full flag agrees with the count.
    `OVL_ASSERT(a_full_flag, (o_m_tvalid && cap_narrow) |-> (full_res == (count == COUNT_W'(CAPACITY))), "full flag mismatch")

    // No result is offered while reset is held.
    `OVL_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_m_tvalid, "result beat after reset")

endmodule

bind ordered_value_list ovl_checker #(
    .CAPACITY (CAPACITY)
) u_ovl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
